### rtl/core/drs_pkg.sv
// package for the dielectric scatter block: word types, scatter codes,
// fixed-point constants and the square-root and saturation helpers
// no dependencies
`default_nettype none

package drs_pkg;

  localparam int FRAC_BITS = 14;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int HALF      = 1 << (FRAC_BITS - 1);

  typedef enum logic [1:0] {
    KIND_REFRACT = 2'd0,
    KIND_TIR     = 2'd1,
    KIND_FRESNEL = 2'd2
  } kind_t;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [15:0]        index_from;
    logic [15:0]        index_to;
    logic [15:0]        rand_sample;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    kind_t              scatter_kind;
  } out_word_t;

  // partial remainder and root of the digit-by-digit square root
  typedef struct packed {
    logic [18:0] rem;
    logic [15:0] root;
  } sq_t;

  // one result bit: bring down two radicand bits, try root*4+1
  function automatic sq_t sqrt_step(input sq_t cur, input logic [1:0] pair);
    logic [18:0] rem2;
    logic [18:0] trial;
    sq_t         res;
    rem2  = {cur.rem[16:0], pair};
    trial = {1'b0, cur.root, 2'b01};
    if (rem2 >= trial) begin
      res.rem  = rem2 - trial;
      res.root = {cur.root[14:0], 1'b1};
    end else begin
      res.rem  = rem2;
      res.root = {cur.root[14:0], 1'b0};
    end
    return res;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
    if (v > 36'sd32767) begin
      return 16'sh7fff;
    end else if (v < -36'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

endpackage

`default_nettype wire

### rtl/core/dielectric_refract_schlick.sv
// dielectric scatter pipeline: snell refraction with schlick reflectance
// depends on drs_pkg
// throughput one word per cycle while output words are taken
// the pipeline length is set by the serial chain of the per-lane divider by n2 (17 stages)
// and the 16-stage square root of the refracted parallel term
// the whole pipeline holds when the output word is not taken
// reset (rst_n low, synchronous) clears the stage valid bits only
`default_nettype none

module dielectric_refract_schlick
  import drs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data
);

  localparam int LAST = 44;

  logic            adv;
  logic [LAST:1]   vld_r;

  logic signed [15:0] in_dir [0:2];
  logic signed [15:0] in_nrm [0:2];

  // carried operands
  logic signed [15:0] dir_r  [0:2][1:3];
  logic signed [15:0] nrm_r  [0:2][1:42];
  logic [15:0]        n1_r   [1:18];
  logic [15:0]        n2_r   [1:22];
  logic [15:0]        samp_r [1:19];

  // cosine and schlick terms
  logic signed [31:0] dp_r [0:2],  dp_nxt [0:2];
  logic [15:0]        ad_r,        ad_nxt;
  logic [16:0]        sm_r,        sm_nxt;
  logic signed [15:0] c_r,         c_nxt;
  logic [31:0]        num_r,       num_nxt;
  logic [33:0]        den_r,       den_nxt;
  logic signed [31:0] cn_r [0:2],  cn_nxt [0:2];
  logic [15:0]        t_r  [3:7];
  logic [16:0]        p_r  [3:7],  p_nxt [4:7];
  logic [14:0]        pz_r [8:18], pz_nxt;

  // r0 divider
  logic [33:0]        dd_r  [3:17];
  logic [47:0]        rq_r  [3:18], rq_nxt  [3:18];
  logic [14:0]        rqq_r [3:18], rqq_nxt [4:18];

  // sin square root
  logic [29:0]        xa_r [3:17], xa_nxt;
  sq_t                sa_r [3:18], sa_nxt [4:18];

  logic               tir_r,  tir_nxt;
  logic [16:0]        refl_r, refl_nxt;
  kind_t              kind_r [20:43], kind_nxt;

  // refraction lanes
  logic signed [17:0] w_r    [0:2],       w_nxt   [0:2];
  logic signed [15:0] rfl_r  [0:2][4:43], rfl_nxt [0:2];
  logic signed [34:0] wn_r   [0:2],       wn_nxt  [0:2];
  logic               neg_r  [0:2][6:23], neg_nxt [0:2];
  logic [32:0]        num6_r [0:2],       num6_nxt[0:2];
  logic               ov_r   [0:2][7:23], ov_nxt  [0:2];
  logic [31:0]        dr_r   [0:2][7:23], dr_nxt  [0:2][7:23];
  logic [15:0]        dq_r   [0:2][8:23], dq_nxt  [0:2][8:23];
  logic signed [15:0] perp_r [0:2][24:43], perp_nxt [0:2];
  logic [31:0]        sq_r   [0:2],       sq_nxt  [0:2];

  // parallel term square root
  logic [31:0]        xb_r [26:41], xb_nxt;
  sq_t                sb_r [27:42], sb_nxt [27:42];
  logic signed [32:0] mn_r [0:2],  mn_nxt [0:2];

  out_word_t          out_r, out_nxt;

  assign in_dir[0] = in_data.dir_x;
  assign in_dir[1] = in_data.dir_y;
  assign in_dir[2] = in_data.dir_z;
  assign in_nrm[0] = in_data.norm_x;
  assign in_nrm[1] = in_data.norm_y;
  assign in_nrm[2] = in_data.norm_z;

  assign adv       = !vld_r[LAST] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[LAST];
  assign out_data  = out_r;

  logic [15:0] n1f, n2f;
  assign n1f = (in_data.index_from == 16'd0) ? 16'd1 : in_data.index_from;
  assign n2f = (in_data.index_to == 16'd0) ? 16'd1 : in_data.index_to;

  always_comb begin
    logic signed [33:0] dot;
    logic signed [34:0] ndot;
    logic signed [34:0] cq;
    logic signed [31:0] cc;
    logic [32:0]        pprod;
    logic [31:0]        tprod;
    logic [29:0]        rprod;
    logic [14:0]        om;
    logic [47:0]        dsh;
    logic [31:0]        dv;
    logic signed [31:0] r1;
    logic signed [32:0] cn2;
    logic signed [32:0] r2;
    logic signed [35:0] ext_a;
    logic signed [35:0] ext_b;
    logic signed [34:0] awn;
    logic [34:0]        ssum;
    logic [34:0]        ld;
    logic signed [32:0] rr;
    logic signed [15:0] o [0:2];
    logic [15:0]        q;

    // stage 1: products and index terms
    for (int i = 0; i < 3; i++) begin
      dp_nxt[i] = in_dir[i] * in_nrm[i];
    end
    ad_nxt = (n1f >= n2f) ? n1f - n2f : n2f - n1f;
    sm_nxt = {1'b0, n1f} + {1'b0, n2f};

    // stage 2: cos, rounded and clamped to [-1, 1]
    dot  = dp_r[0];
    dot  = dot + dp_r[1];
    dot  = dot + dp_r[2];
    ndot = dot;
    ndot = HALF - ndot;
    cq   = ndot >>> FRAC_BITS;
    if (cq > ONE) begin
      c_nxt = 16'(ONE);
    end else if (cq < -ONE) begin
      c_nxt = -16'(ONE);
    end else begin
      c_nxt = cq[15:0];
    end
    num_nxt = ad_r * ad_r;
    den_nxt = sm_r * sm_r;

    // stage 3
    cc     = c_r * c_r;
    xa_nxt = 30'(ONE * ONE) - 30'(cc[28:0]);
    for (int i = 0; i < 3; i++) begin
      cn_nxt[i] = c_r * nrm_r[i][2];
    end
    rq_nxt[3] = {2'b0, num_r, 14'b0} + {15'b0, den_r[33:1]};

    // r0 divider, one quotient bit a stage
    for (int s = 4; s <= 18; s++) begin
      dsh = {14'b0, dd_r[s-1]} << (18 - s);
      if (rq_r[s-1] >= dsh) begin
        rq_nxt[s]  = rq_r[s-1] - dsh;
        rqq_nxt[s] = rqq_r[s-1] | (15'd1 << (18 - s));
      end else begin
        rq_nxt[s]  = rq_r[s-1];
        rqq_nxt[s] = rqq_r[s-1];
      end
    end

    // sin = isqrt(1 - cos^2)
    for (int s = 4; s <= 18; s++) begin
      sa_nxt[s] = sqrt_step(sa_r[s-1], xa_r[s-1][29-2*(s-4) -: 2]);
    end

    // (1 - cos)^5 by repeated rounded multiply
    for (int s = 4; s <= 7; s++) begin
      pprod    = p_r[s-1] * t_r[s-1];
      pprod    = pprod + 33'(HALF);
      p_nxt[s] = pprod[FRAC_BITS +: 17];
    end
    pz_nxt = (t_r[7] >= 16'(ONE)) ? 15'(ONE) : p_r[7][14:0];

    // stage 19: total internal reflection test and reflectance
    tprod   = sa_r[18].root * n1_r[18];
    tir_nxt = tprod > {2'b0, n2_r[18], 14'b0};
    om      = 15'(ONE) - rqq_r[18];
    rprod   = om * pz_r[18];
    rprod   = rprod + 30'(HALF);
    refl_nxt = {2'b0, rqq_r[18]} + 17'(rprod[29:FRAC_BITS]);

    // stage 20
    if (tir_r) begin
      kind_nxt = KIND_TIR;
    end else if ({refl_r, 2'b0} > {3'b0, samp_r[19]}) begin
      kind_nxt = KIND_FRESNEL;
    end else begin
      kind_nxt = KIND_REFRACT;
    end

    for (int i = 0; i < 3; i++) begin
      // stage 4: perp numerator and reflected ray
      r1       = (cn_r[i] + 32'sd4096 + 32'sd4096) >>> FRAC_BITS;
      ext_a    = dir_r[i][3];
      ext_b    = r1;
      ext_a    = ext_a + ext_b;
      w_nxt[i] = ext_a[17:0];
      cn2      = cn_r[i];
      cn2      = cn2 <<< 1;
      r2       = (cn2 + 33'sd8192) >>> FRAC_BITS;
      ext_a    = dir_r[i][3];
      ext_b    = r2;
      rfl_nxt[i] = sat16(ext_a + ext_b);

      // stage 5, 6
      wn_nxt[i]   = w_r[i] * $signed({1'b0, n1_r[4]});
      awn         = wn_r[i][34] ? -wn_r[i] : wn_r[i];
      neg_nxt[i]  = wn_r[i][34];
      num6_nxt[i] = {1'b0, awn[31:0]} + {18'b0, n2_r[5][15:1]};

      // stage 7: quotient overflow
      ov_nxt[i]    = num6_r[i] >= {1'b0, n2_r[6], 16'b0};
      dr_nxt[i][7] = ov_nxt[i] ? 32'd0 : num6_r[i][31:0];

      // stages 8..23: divide by n2, one bit a stage
      for (int s = 8; s <= 23; s++) begin
        dv = {16'b0, n2_r[s-1]} << (23 - s);
        if (dr_r[i][s-1] >= dv) begin
          dr_nxt[i][s] = dr_r[i][s-1] - dv;
          dq_nxt[i][s] = ((s == 8) ? 16'd0 : dq_r[i][(s == 8) ? 8 : s-1])
                         | (16'd1 << (23 - s));
        end else begin
          dr_nxt[i][s] = dr_r[i][s-1];
          dq_nxt[i][s] = (s == 8) ? 16'd0 : dq_r[i][(s == 8) ? 8 : s-1];
        end
      end

      // stage 24: saturate perp
      q = dq_r[i][23];
      if (neg_r[i][23]) begin
        perp_nxt[i] = (ov_r[i][23] || q > 16'd32768) ? 16'sh8000 : $signed(-q);
      end else begin
        perp_nxt[i] = (ov_r[i][23] || q > 16'd32767) ? 16'sh7fff : $signed(q);
      end

      // stage 25
      cc        = perp_r[i][24] * perp_r[i][24];
      sq_nxt[i] = cc;
    end

    // stage 26: |1 - |perp|^2|
    ssum = 35'(sq_r[0]) + 35'(sq_r[1]) + 35'(sq_r[2]);
    ld   = 35'(ONE * ONE) - ssum;
    if (ld[34]) begin
      ld = ~ld + 35'd1;
    end
    xb_nxt = ld[31:0];

    // stages 27..42: parallel term square root
    for (int s = 27; s <= 42; s++) begin
      sb_nxt[s] = sqrt_step((s == 27) ? sq_t'('0) : sb_r[(s == 27) ? 27 : s-1],
                            xb_r[s-1][31-2*(s-27) -: 2]);
    end

    // stages 43, 44
    for (int i = 0; i < 3; i++) begin
      mn_nxt[i] = $signed({1'b0, sb_r[42].root}) * nrm_r[i][42];
      rr        = (mn_r[i] + 33'sd8192) >>> FRAC_BITS;
      ext_a     = perp_r[i][43];
      ext_b     = rr;
      o[i]      = sat16(ext_a - ext_b);
      if (kind_r[43] != KIND_REFRACT) begin
        o[i] = rfl_r[i][43];
      end
    end
    out_nxt.out_x        = o[0];
    out_nxt.out_y        = o[1];
    out_nxt.out_z        = o[2];
    out_nxt.scatter_kind = kind_r[43];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAST-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dir_r[i][1] <= in_dir[i];
        nrm_r[i][1] <= in_nrm[i];
        for (int s = 2; s <= 3; s++) dir_r[i][s] <= dir_r[i][s-1];
        for (int s = 2; s <= 42; s++) nrm_r[i][s] <= nrm_r[i][s-1];
        dp_r[i] <= dp_nxt[i];
        cn_r[i] <= cn_nxt[i];
        w_r[i]  <= w_nxt[i];
        rfl_r[i][4] <= rfl_nxt[i];
        for (int s = 5; s <= 43; s++) rfl_r[i][s] <= rfl_r[i][s-1];
        wn_r[i]     <= wn_nxt[i];
        neg_r[i][6] <= neg_nxt[i];
        for (int s = 7; s <= 23; s++) neg_r[i][s] <= neg_r[i][s-1];
        num6_r[i]   <= num6_nxt[i];
        ov_r[i][7]  <= ov_nxt[i];
        for (int s = 8; s <= 23; s++) ov_r[i][s] <= ov_r[i][s-1];
        dr_r[i][7]  <= dr_nxt[i][7];
        for (int s = 8; s <= 23; s++) begin
          dr_r[i][s] <= dr_nxt[i][s];
          dq_r[i][s] <= dq_nxt[i][s];
        end
        perp_r[i][24] <= perp_nxt[i];
        for (int s = 25; s <= 43; s++) perp_r[i][s] <= perp_r[i][s-1];
        sq_r[i] <= sq_nxt[i];
        mn_r[i] <= mn_nxt[i];
      end
      n1_r[1]   <= n1f;
      n2_r[1]   <= n2f;
      samp_r[1] <= in_data.rand_sample;
      for (int s = 2; s <= 18; s++) n1_r[s] <= n1_r[s-1];
      for (int s = 2; s <= 22; s++) n2_r[s] <= n2_r[s-1];
      for (int s = 2; s <= 19; s++) samp_r[s] <= samp_r[s-1];
      ad_r  <= ad_nxt;
      sm_r  <= sm_nxt;
      c_r   <= c_nxt;
      num_r <= num_nxt;
      den_r <= den_nxt;

      dd_r[3]  <= den_r;
      for (int s = 4; s <= 17; s++) dd_r[s] <= dd_r[s-1];
      rq_r[3]  <= rq_nxt[3];
      rqq_r[3] <= '0;
      for (int s = 4; s <= 18; s++) begin
        rq_r[s]  <= rq_nxt[s];
        rqq_r[s] <= rqq_nxt[s];
        sa_r[s]  <= sa_nxt[s];
      end
      xa_r[3] <= xa_nxt;
      for (int s = 4; s <= 17; s++) xa_r[s] <= xa_r[s-1];
      sa_r[3] <= '0;

      t_r[3] <= 16'(17'(ONE) - 17'(c_r));
      for (int s = 4; s <= 7; s++) t_r[s] <= t_r[s-1];
      p_r[3] <= {1'b0, 16'(17'(ONE) - 17'(c_r))};
      for (int s = 4; s <= 7; s++) p_r[s] <= p_nxt[s];
      pz_r[8] <= pz_nxt;
      for (int s = 9; s <= 18; s++) pz_r[s] <= pz_r[s-1];

      tir_r      <= tir_nxt;
      refl_r     <= refl_nxt;
      kind_r[20] <= kind_nxt;
      for (int s = 21; s <= 43; s++) kind_r[s] <= kind_r[s-1];

      xb_r[26] <= xb_nxt;
      for (int s = 27; s <= 41; s++) xb_r[s] <= xb_r[s-1];
      for (int s = 27; s <= 42; s++) sb_r[s] <= sb_nxt[s];

      out_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/drs_check.sv
// port-level checks for the dielectric scatter pipeline, bound to the top level
// depends on drs_pkg
`default_nettype none

module drs_check
  import drs_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_word_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_word_t out_data
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  // the pipeline moves exactly when its last stage is free or drained
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow the output stall");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output word valid right after reset");

endmodule

bind dielectric_refract_schlick drs_check u_drs_check (.*);

`default_nettype wire

### test/tb_dielectric_refract_schlick.sv
// testbench for dielectric_refract_schlick: directed and random ray hits,
// checked against a behavioral scatter predictor; depends on drs_pkg and the rtl
`timescale 1ns / 1ps

module tb_dielectric_refract_schlick;
  import drs_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_word_t in_data;
  logic out_valid;
  logic out_ready;
  out_word_t out_data;

  out_word_t scatter_q[$];
  int errors;
  int sent;
  int received;
  int n_refract, n_tir, n_fresnel;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;
  longint cycles;

  dielectric_refract_schlick dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // round to nearest, ties toward +inf
  function automatic longint rnd_fb(longint x);
    return (x + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic longint sat_s16(longint v);
    if (v > 32767) begin
      return 32767;
    end else if (v < -32768) begin
      return -32768;
    end
    return v;
  endfunction

  function automatic longint int_sqrt(longint x);
    longint r;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= x) begin
        r = r + (longint'(1) << b);
      end
    end
    return r;
  endfunction

  function automatic out_word_t scatter_of(in_word_t w);
    longint d[3], n[3], o[3], perp[3];
    longint n1, n2, c, dt, s, diff, sm, num, den, r0, t, p, refl, wv, q, mag, len2, m, one;
    kind_t k;
    out_word_t res;
    one = ONE;
    d[0] = w.dir_x; d[1] = w.dir_y; d[2] = w.dir_z;
    n[0] = w.norm_x; n[1] = w.norm_y; n[2] = w.norm_z;
    n1 = w.index_from;
    n2 = w.index_to;
    if (n1 == 0) n1 = 1;
    if (n2 == 0) n2 = 1;
    dt = d[0] * n[0] + d[1] * n[1] + d[2] * n[2];
    c = rnd_fb(-dt);
    if (c > one) c = one;
    if (c < -one) c = -one;
    s = int_sqrt(one * one - c * c);
    if (s * n1 > n2 * one) begin
      k = KIND_TIR;
    end else begin
      diff = n1 - n2;
      sm = n1 + n2;
      num = diff * diff;
      den = sm * sm;
      r0 = (num * one + den / 2) / den;
      t = one - c;
      if (t >= one) begin
        p = one;
      end else begin
        p = t;
        for (int i = 0; i < 4; i++) p = rnd_fb(p * t);
      end
      refl = r0 + rnd_fb((one - r0) * p);
      k = ((refl << 16) > (longint'(w.rand_sample) << FRAC_BITS)) ? KIND_FRESNEL
                                                                 : KIND_REFRACT;
    end
    if (k != KIND_REFRACT) begin
      for (int i = 0; i < 3; i++) o[i] = d[i] + rnd_fb(2 * c * n[i]);
    end else begin
      for (int i = 0; i < 3; i++) begin
        wv = d[i] + rnd_fb(c * n[i]);
        q = wv * n1;
        mag = (q < 0) ? -q : q;
        mag = (mag + n2 / 2) / n2;
        perp[i] = sat_s16((q < 0) ? -mag : mag);
      end
      len2 = one * one - (perp[0] * perp[0] + perp[1] * perp[1] + perp[2] * perp[2]);
      if (len2 < 0) len2 = -len2;
      m = int_sqrt(len2);
      for (int i = 0; i < 3; i++) o[i] = perp[i] - rnd_fb(m * n[i]);
    end
    res.out_x = 16'(sat_s16(o[0]));
    res.out_y = 16'(sat_s16(o[1]));
    res.out_z = 16'(sat_s16(o[2]));
    res.scatter_kind = k;
    return res;
  endfunction

  task automatic send_word(in_word_t w);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    scatter_q.push_back(scatter_of(w));
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (scatter_q.size() != 0) @(posedge clk);
  endtask

  function automatic in_word_t hit_of(int dx, int dy, int dz, int nx, int ny, int nz,
                                      int n1, int n2, int smp);
    in_word_t w;
    w.dir_x = 16'(dx); w.dir_y = 16'(dy); w.dir_z = 16'(dz);
    w.norm_x = 16'(nx); w.norm_y = 16'(ny); w.norm_z = 16'(nz);
    w.index_from = 16'(n1); w.index_to = 16'(n2); w.rand_sample = 16'(smp);
    return w;
  endfunction

  // roughly unit vector: random on a face, then scaled
  function automatic void unit_vec(output int x, output int y, output int z);
    int a, b, l;
    a = $urandom_range(32767) - 16384;
    b = $urandom_range(32767) - 16384;
    l = int'(int_sqrt(longint'(a) * a + longint'(b) * b + 16384 * 16384));
    x = (a * 16384) / l;
    y = (b * 16384) / l;
    z = (16384 * 16384) / l;
    if ($urandom_range(1)) z = -z;
    case ($urandom_range(2))
      0: begin l = x; x = z; z = l; end
      1: begin l = y; y = z; z = l; end
      default: ;
    endcase
  endfunction

  function automatic in_word_t random_hit();
    in_word_t w;
    int dx, dy, dz, nx, ny, nz;
    if ($urandom_range(9) == 0) begin
      w = in_word_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    end else begin
      unit_vec(dx, dy, dz);
      unit_vec(nx, ny, nz);
      w = hit_of(dx, dy, dz, nx, ny, nz, $urandom_range(16384, 40000),
                 $urandom_range(16384, 40000), $urandom_range(65535));
      if ($urandom_range(7) == 0) w.index_from = 16'($urandom);
      if ($urandom_range(7) == 0) w.index_to = 16'($urandom);
    end
    return w;
  endfunction

  task automatic test_directed();
    send_word(hit_of(0, 0, -16384, 0, 0, 16384, 16384, 24576, 65535));
    send_word(hit_of(0, 0, -16384, 0, 0, 16384, 16384, 24576, 0));
    send_word(hit_of(11585, 0, -11585, 0, 0, 16384, 16384, 24576, 65535));
    send_word(hit_of(11585, 0, -11585, 0, 0, 16384, 24576, 16384, 65535));
    send_word(hit_of(15000, 0, -6000, 0, 0, 16384, 24576, 16384, 65535));
    // ray from behind the surface
    send_word(hit_of(0, 0, 16384, 0, 0, 16384, 16384, 16384, 65535));
    send_word(hit_of(8000, 0, 14000, 0, 0, 16384, 16384, 65535, 100));
    // zero indexes
    send_word(hit_of(0, 6000, -15000, 0, 0, 16384, 0, 0, 30000));
    send_word(hit_of(0, 6000, -15000, 0, 0, 16384, 0, 65535, 30000));
    send_word(hit_of(0, 6000, -15000, 0, 0, 16384, 65535, 0, 30000));
    // non-unit vectors and saturation
    send_word(hit_of(32767, 32767, 32767, -32768, -32768, -32768, 65535, 16384, 0));
    send_word(hit_of(-32768, -32768, -32768, -32768, -32768, -32768, 16384, 65535, 65535));
    send_word(hit_of(32767, -32768, 0, 32767, 32767, 0, 65535, 1, 65535));
    send_word(hit_of(-32768, 32767, -32768, 1, -1, 32767, 1, 65535, 0));
    send_word(hit_of(20000, 0, -2000, 0, 0, 32767, 40000, 16384, 65535));
    send_word(hit_of(0, 0, 0, 0, 0, 0, 16384, 16384, 0));
    send_word(hit_of(-1, -1, -1, -1, -1, -1, 65535, 65535, 65535));
    drain();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_word(random_hit());
  endtask

  // stall the receiver long enough that the pipeline fills and blocks input
  task automatic test_backpressure();
    recv_idle_pct = 0;
    hold_cycles = 150;
    test_random(120);
    drain();
  endtask

  initial begin
    errors = 0; sent = 0; received = 0;
    n_refract = 0; n_tir = 0; n_fresnel = 0;
    hold_cycles = 0;
    in_valid = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    send_idle_pct = 29; recv_idle_pct = 57;
    test_random(500);
    drain();
    send_idle_pct = 57; recv_idle_pct = 29;
    test_random(500);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(500);
    drain();
    test_backpressure();
    drain();
    repeat (60) @(posedge clk);
    $display("covered %0d hits: %0d refracted, %0d total internal, %0d fresnel",
             received, n_refract, n_tir, n_fresnel);
    $display("handshake idling on both sides plus a long receiver hold");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // receiver side ready
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      received++;
      if (scatter_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word %h", $time, out_data);
      end else begin
        exp_w = scatter_q.pop_front();
        case (exp_w.scatter_kind)
          KIND_REFRACT: n_refract++;
          KIND_TIR: n_tir++;
          default: n_fresnel++;
        endcase
        if (out_data.out_x !== exp_w.out_x || out_data.out_y !== exp_w.out_y ||
            out_data.out_z !== exp_w.out_z ||
            out_data.scatter_kind !== exp_w.scatter_kind) begin
          errors++;
          $display("%0t: mismatch expected %0d %0d %0d kind %0d, got %0d %0d %0d kind %0d",
                   $time, exp_w.out_x, exp_w.out_y, exp_w.out_z, exp_w.scatter_kind,
                   out_data.out_x, out_data.out_y, out_data.out_z, out_data.scatter_kind);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial cycles = 0;

endmodule

### sim.f
rtl/core/drs_pkg.sv
rtl/core/dielectric_refract_schlick.sv
rtl/core/drs_check.sv
test/tb_dielectric_refract_schlick.sv
